// ===== rtl/core/fba_pkg.sv =====
// Shared constants, types and helper functions for the frame bitmap allocator.
// Depends on nothing; every other file of the block but fba_ram imports it.
package fba_pkg;

   localparam int FRAME_COUNT = 65536;
   localparam int PAGE_SHIFT  = 12;

   localparam int WORD_BITS = 64;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int FRAME_W   = $clog2(FRAME_COUNT);

   localparam int FUNC_W  = 2;
   localparam int REL_W   = 48;
   localparam int ADDR_W  = 28;
   localparam int COUNT_W = 18;
   localparam int RANGE_W = 17;
   localparam int KERN_W  = 17;
   localparam int BASE_W  = 16;
   localparam int REGN_W  = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // Width wide enough for every frame position compared inside one row.
   localparam int EXT_A = (WORD_AW + BIT_W + 2 > 19) ? WORD_AW + BIT_W + 2 : 19;
   localparam int EXT_W = (FRAME_W + 2 > EXT_A) ? FRAME_W + 2 : EXT_A;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INIT  = 2'd0,
      FUNC_ALLOC = 2'd1,
      FUNC_FREE  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAMES_IN_USE = 2'd0,
      CSR_KERNEL_FRAMES = 2'd1,
      CSR_REGION_BASE   = 2'd2,
      CSR_REGION_FRAMES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] frames_in_use_range;
      logic [KERN_W-1:0]  kernel_frames;
      logic [BASE_W-1:0]  map_region_base;
      logic [REGN_W-1:0]  map_region_frames;
   } cfg_type;

   typedef struct packed {
      logic                 hit;
      logic                 last;
      logic [WORD_BITS-1:0] free_vec;
   } scan_type;

   // Bits of the row starting at frame lo whose frame index lies below n.
   function automatic logic [WORD_BITS-1:0] below_mask(input logic [EXT_W-1:0] n,
                                                       input logic [EXT_W-1:0] lo);
      logic [EXT_W-1:0]     d;
      logic [WORD_BITS-1:0] m;
      d = n - lo;
      if (n <= lo) begin
         m = '0;
      end else if (d >= EXT_W'(WORD_BITS)) begin
         m = '1;
      end else begin
         m = ~({WORD_BITS{1'b1}} << d[BIT_W-1:0]);
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/frame_bitmap_allocator_core.sv =====
// Top level of the first-fit bitmap page frame allocator.
// Depends on fba_pkg, fba_ram, fba_reserve_mask and fba_scan.
//
//   Channel   Direction  Handshake           Contents
//   req_*     in         req_valid/req_stall func, release_address
//   rsp_*     out        rsp_valid/rsp_stall frame_address, ok, used_count
//   csr_*     in         csr_write_enable    csr_index, csr_write_data
//
// The used bits live in a RAM of MAP_WORDS rows of 64 bits (1024 rows here), one row
// per cycle through its single read port. An allocation reads rows from row 0 until
// one holds a free managed frame, then sets its lowest free bit, writes the row back
// and replies; a failed allocation reads every row that holds managed frames. A free
// reads the frame's row and clears the bit if set; a frame outside the managed range,
// like the idle selector, goes straight to the reply. An init rewrites every row.
// After reset the same sweep clears the map, so no word is accepted until it ends.
// A finished result waits in the output register while the next word is accepted.
module frame_bitmap_allocator_core
   import fba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [REL_W-1:0]      req_release_address,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_W-1:0]     rsp_frame_address,
   output logic                  rsp_ok,
   output logic [COUNT_W-1:0]    rsp_used_count,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int REL_IDX_W = REL_W - PAGE_SHIFT;
   localparam int CMP_W     = (REL_IDX_W > EXT_W) ? REL_IDX_W : EXT_W;
   localparam int FIDX_W    = WORD_AW + BIT_W;
   localparam int SH_W      = (FIDX_W + PAGE_SHIFT > ADDR_W) ? FIDX_W + PAGE_SHIFT : ADDR_W;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SWEEP   = 6'b000010,
      ST_A_CHECK = 6'b000100,
      ST_A_PICK  = 6'b001000,
      ST_F_CHECK = 6'b010000,
      ST_REPLY   = 6'b100000
   } state_type;

   // Position of the lowest set bit, found by halving the word six times.
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v_in);
      logic [WORD_BITS-1:0] v;
      logic [WORD_BITS-1:0] low;
      logic [BIT_W-1:0]     pos;
      v   = v_in;
      pos = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         low = ~({WORD_BITS{1'b1}} << (1 << k));
         if ((v & low) == '0) begin
            pos[k] = 1'b1;
            v      = v >> (1 << k);
         end
      end
      return pos;
   endfunction

   state_type            state_ff, state_in;
   cfg_type              cfg_ff, cfg_in;
   logic [WORD_AW-1:0]   row_ff, row_in;
   logic                 clear_only_ff, clear_only_in;
   logic [COUNT_W-1:0]   used_ff, used_in;
   logic [WORD_BITS-1:0] free_vec_ff, free_vec_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                 pend_ok_ff, pend_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                 ram_wr_en;
   logic [WORD_AW-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [WORD_AW-1:0]   ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   logic [WORD_BITS-1:0] init_row;
   scan_type             scan;
   logic [EXT_W-1:0]     range_ext;
   logic [EXT_W-1:0]     limit;
   logic [REL_IDX_W-1:0] rel_idx;
   logic                 rel_in_range;
   logic                 req_take;
   logic                 slot_free;
   logic [BIT_W-1:0]     pick_pos;
   logic [SH_W-1:0]      pick_addr;
   func_type             func;

   fba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fba_reserve_mask u_reserve (
      .cfg        (cfg_ff),
      .row        (row_ff),
      .clear_only (clear_only_ff),
      .row_data   (init_row)
   );

   fba_scan u_scan (
      .row_data (ram_rd_data),
      .row      (row_ff),
      .limit    (limit),
      .scan     (scan)
   );

   // The managed frame count is read live and capped at the size of the map.
   assign range_ext = EXT_W'(cfg_ff.frames_in_use_range);
   assign limit     = (range_ext > EXT_W'(FRAME_COUNT)) ? EXT_W'(FRAME_COUNT) : range_ext;

   assign rel_idx      = req_release_address[REL_W-1:PAGE_SHIFT];
   assign rel_in_range = (CMP_W'(rel_idx) < CMP_W'(limit));

   assign func      = func_type'(req_func);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign pick_pos  = lowest_set(free_vec_ff);
   assign pick_addr = SH_W'({row_ff, pick_pos}) << PAGE_SHIFT;

   // Configuration writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FRAMES_IN_USE: cfg_in.frames_in_use_range = csr_write_data[RANGE_W-1:0];
            CSR_KERNEL_FRAMES: cfg_in.kernel_frames       = csr_write_data[KERN_W-1:0];
            CSR_REGION_BASE:   cfg_in.map_region_base     = csr_write_data[BASE_W-1:0];
            CSR_REGION_FRAMES: cfg_in.map_region_frames   = csr_write_data[REGN_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: allocations and frees read a row, modify it and write it back; an init sweeps every row.
   // Only one operation is in flight, so a write always lands before the next read.
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      clear_only_in = clear_only_ff;
      used_in       = used_ff;
      free_vec_in   = free_vec_ff;
      bit_in        = bit_ff;
      pend_addr_in  = pend_addr_ff;
      pend_ok_in    = pend_ok_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = row_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = row_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pend_addr_in = '0;
               pend_ok_in   = 1'b0;
               case (func)
                  FUNC_INIT: begin
                     // Each reserved frame counts, overlaps and out-of-map frames too.
                     used_in       = COUNT_W'(cfg_ff.kernel_frames) +
                                     COUNT_W'(cfg_ff.map_region_frames);
                     row_in        = '0;
                     clear_only_in = 1'b0;
                     state_in      = ST_SWEEP;
                  end
                  FUNC_ALLOC: begin
                     if (limit == '0) begin
                        state_in = ST_REPLY;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        row_in      = '0;
                        state_in    = ST_A_CHECK;
                     end
                  end
                  FUNC_FREE: begin
                     if (rel_in_range) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = rel_idx[FIDX_W-1:BIT_W];
                        row_in      = rel_idx[FIDX_W-1:BIT_W];
                        bit_in      = rel_idx[BIT_W-1:0];
                        state_in    = ST_F_CHECK;
                     end else begin
                        state_in = ST_REPLY;
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = row_ff;
            ram_wr_data = init_row;
            row_in      = row_ff + 1'b1;
            if (row_ff == WORD_AW'(MAP_WORDS - 1)) begin
               // The reset clearing pass has no result; an init does.
               state_in = clear_only_ff ? ST_IDLE : ST_REPLY;
            end
         end
         ST_A_CHECK: begin
            if (scan.hit) begin
               free_vec_in = scan.free_vec;
               state_in    = ST_A_PICK;
            end else if (scan.last) begin
               state_in = ST_REPLY;
            end else begin
               // Fetch the following row so that one row is examined each cycle.
               ram_rd_en   = 1'b1;
               ram_rd_addr = row_ff + 1'b1;
               row_in      = row_ff + 1'b1;
            end
         end
         ST_A_PICK: begin
            ram_wr_en    = 1'b1;
            ram_wr_data  = ram_rd_data | (WORD_BITS'(1) << pick_pos);
            used_in      = used_ff + 1'b1;
            pend_addr_in = pick_addr[ADDR_W-1:0];
            pend_ok_in   = 1'b1;
            state_in     = ST_REPLY;
         end
         ST_F_CHECK: begin
            if (ram_rd_data[bit_ff]) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << bit_ff);
               used_in     = used_ff - 1'b1;
               pend_ok_in  = 1'b1;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded from the pending result when the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_REPLY) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = pend_addr_ff;
         rsp_ok_in    = pend_ok_ff;
         rsp_count_in = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         row_ff        <= '0;
         clear_only_ff <= 1'b1;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         cfg_ff.frames_in_use_range <= '0;
         cfg_ff.kernel_frames       <= '0;
         cfg_ff.map_region_base     <= '0;
         cfg_ff.map_region_frames   <= REGN_W'(2);
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         clear_only_ff <= clear_only_in;
         used_ff       <= used_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      free_vec_ff  <= free_vec_in;
      bit_ff       <= bit_in;
      pend_addr_ff <= pend_addr_in;
      pend_ok_ff   <= pend_ok_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_used_count    = rsp_count_ff;

endmodule

// ===== rtl/core/fba_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; width and depth are set by the instantiating module.
module fba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fba_reserve_mask.sv =====
// Builds the contents of one map row as written by the init sweep.
// Depends on fba_pkg for the configuration struct and row mask helper.
module fba_reserve_mask
   import fba_pkg::*;
(
   input  cfg_type              cfg,
   input  logic [WORD_AW-1:0]   row,
   input  logic                 clear_only,
   output logic [WORD_BITS-1:0] row_data
);

   logic [EXT_W-1:0]     row_lo;
   logic [EXT_W-1:0]     region_lo;
   logic [EXT_W-1:0]     region_end;
   logic [WORD_BITS-1:0] kernel_bits;
   logic [WORD_BITS-1:0] region_bits;

   always_comb begin
      row_lo      = EXT_W'(row) << BIT_W;
      region_lo   = EXT_W'(cfg.map_region_base);
      region_end  = EXT_W'(cfg.map_region_base) + EXT_W'(cfg.map_region_frames);
      kernel_bits = below_mask(EXT_W'(cfg.kernel_frames), row_lo);
      region_bits = below_mask(region_end, row_lo) & ~below_mask(region_lo, row_lo);
      row_data    = clear_only ? '0 : (kernel_bits | region_bits);
   end

endmodule

// ===== rtl/core/fba_scan.sv =====
// Examines one map row during an allocation scan: free frames below the limit.
// Depends on fba_pkg for the row mask helper and the scan result struct.
module fba_scan
   import fba_pkg::*;
(
   input  logic [WORD_BITS-1:0] row_data,
   input  logic [WORD_AW-1:0]   row,
   input  logic [EXT_W-1:0]     limit,
   output scan_type             scan
);

   logic [EXT_W-1:0] row_lo;

   always_comb begin
      row_lo        = EXT_W'(row) << BIT_W;
      scan.free_vec = ~row_data & below_mask(limit, row_lo);
      scan.hit      = (scan.free_vec != '0);
      // This is the final row that holds any managed frame.
      scan.last     = ((row_lo + EXT_W'(WORD_BITS)) >= limit);
   end

endmodule
